>>> sv/nfps_pkg.sv
// ---------------------------------------------------------------------------
// Newton fractal solver package
// Shared codes, limits and the command and status types that join the
// controller and the datapath.
// ---------------------------------------------------------------------------
package nfps_pkg;

  // Fixed number formats.
  localparam int MUL_W   = 32;   // multiplier operand width
  localparam int SQ_W    = 65;   // exact sum of two 64-bit squares
  localparam int DEN_W   = 64;   // divisor width
  localparam int QUO_W   = 60;   // internal quotient register
  localparam int CAP_W   = 59;   // saturated quotient width
  localparam int NUM_W   = 47;   // weight magnitude times part magnitude
  localparam int NORM_W  = 31;   // normalized parts stay below 2^31
  localparam int SMALL_W = 16;   // step parts below 2^16 are checked for tolerance
  localparam int WEIGHT_FRAC = 12;

  // Per part saturation limits of the two divisions.
  localparam logic [CAP_W-1:0] TERM_CAP = (CAP_W'(1) << 58) - CAP_W'(1);
  localparam logic [CAP_W-1:0] STEP_CAP = CAP_W'(1) << 40;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ITERATION_LIMIT = 2'd0;
  localparam logic [1:0] CFG_ZERO_COUNT      = 2'd1;
  localparam logic [1:0] CFG_TOLERANCE_SQ    = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [7:0]  RESET_ITERATION_LIMIT = 8'd50;
  localparam logic [2:0]  RESET_ZERO_COUNT      = 3'd3;
  localparam logic [31:0] RESET_TOLERANCE_SQ    = 32'd72058;

  // Datapath operations.
  typedef logic [4:0] dp_op_t;
  localparam dp_op_t DP_NOP        = 5'd0;
  localparam dp_op_t DP_LOAD       = 5'd1;
  localparam dp_op_t DP_INIT       = 5'd2;
  localparam dp_op_t DP_ITER       = 5'd3;
  localparam dp_op_t DP_DIFF       = 5'd4;
  localparam dp_op_t DP_TNORM      = 5'd5;
  localparam dp_op_t DP_NMAG       = 5'd6;
  localparam dp_op_t DP_SQ_RE      = 5'd7;
  localparam dp_op_t DP_SQ_IM      = 5'd8;
  localparam dp_op_t DP_NUM_RE     = 5'd9;
  localparam dp_op_t DP_NUM_IM     = 5'd10;
  localparam dp_op_t DP_TDIV       = 5'd11;
  localparam dp_op_t DP_TACC       = 5'd12;
  localparam dp_op_t DP_SNORM_INIT = 5'd13;
  localparam dp_op_t DP_SNORM_STEP = 5'd14;
  localparam dp_op_t DP_PDIV       = 5'd15;
  localparam dp_op_t DP_UPDATE     = 5'd16;
  localparam dp_op_t DP_NCMP       = 5'd17;
  localparam dp_op_t DP_OUT        = 5'd18;

  typedef struct packed {
    dp_op_t     op;
    logic [7:0] iterations;
  } dp_cmd_t;

  typedef struct packed {
    logic diff_zero;   // z equals the selected zero
    logic sum_zero;    // the weighted sum is zero
    logic norm_ok;     // sum parts are normalized
    logic div_done;    // divider finished this cycle
    logic small_step;  // both step parts below 2^16
    logic below_tol;   // squared step below the tolerance
  } dp_status_t;

endpackage

>>> sv/nfps_divider.sv
// ---------------------------------------------------------------------------
// Newton fractal solver divider
// Restoring divider, one quotient bit per cycle, with two lanes that share
// the divisor. Quotients saturate to the selected limit.
// ---------------------------------------------------------------------------
module nfps_divider #(
  parameter int DW = 91
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      step_mode,
  input  logic [DW-1:0]             num_re,
  input  logic [DW-1:0]             num_im,
  input  logic [nfps_pkg::DEN_W-1:0] den,
  output logic                      done,
  output logic [nfps_pkg::CAP_W-1:0] quo_re,
  output logic [nfps_pkg::CAP_W-1:0] quo_im
);
  import nfps_pkg::*;

  localparam int CW = $clog2(DW + 1);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic             mode;
  logic [DEN_W-1:0] den_r;
  logic [DW-1:0]    dvd_re, dvd_im;
  logic [DEN_W-1:0] rem_re, rem_im;
  logic [QUO_W-1:0] q_re, q_im;
  logic             ovf_re, ovf_im;

  logic [DEN_W-1:0] sh_re, sh_im;
  logic             ge_re, ge_im;
  logic [CAP_W-1:0] cap;

  // One restoring step for each lane.
  always_comb begin
    sh_re = {rem_re[DEN_W-2:0], dvd_re[DW-1]};
    sh_im = {rem_im[DEN_W-2:0], dvd_im[DW-1]};
    ge_re = sh_re >= den_r;
    ge_im = sh_im >= den_r;
  end

  // Control of the bit loop.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Dividend, remainder and quotient registers.
  always_ff @(posedge clk) begin
    if (start) begin
      mode   <= step_mode;
      den_r  <= den;
      dvd_re <= num_re;
      dvd_im <= num_im;
      rem_re <= '0;
      rem_im <= '0;
      q_re   <= '0;
      q_im   <= '0;
      ovf_re <= 1'b0;
      ovf_im <= 1'b0;
    end else if (busy) begin
      dvd_re <= dvd_re << 1;
      dvd_im <= dvd_im << 1;
      rem_re <= ge_re ? sh_re - den_r : sh_re;
      rem_im <= ge_im ? sh_im - den_r : sh_im;
      q_re   <= {q_re[QUO_W-2:0], ge_re};
      q_im   <= {q_im[QUO_W-2:0], ge_im};
      ovf_re <= ovf_re | q_re[QUO_W-1];
      ovf_im <= ovf_im | q_im[QUO_W-1];
    end
  end

  // Saturation of the finished quotients.
  always_comb begin
    cap    = mode ? STEP_CAP : TERM_CAP;
    quo_re = (ovf_re || (q_re > QUO_W'(cap))) ? cap : q_re[CAP_W-1:0];
    quo_im = (ovf_im || (q_im > QUO_W'(cap))) ? cap : q_im[CAP_W-1:0];
  end

endmodule

>>> sv/nfps_datapath.sv
// ---------------------------------------------------------------------------
// Newton fractal solver datapath
// Zero table, iterate, weighted sum, shared multiplier and divider, and the
// nearest zero search, driven by one operation code per cycle.
// ---------------------------------------------------------------------------
module nfps_datapath #(
  parameter int MAX_ZEROS = 4,
  parameter int FRAC_BITS = 28,
  localparam int IW = (MAX_ZEROS > 1) ? $clog2(MAX_ZEROS) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  nfps_pkg::dp_cmd_t         cmd,
  input  logic [IW-1:0]             idx,
  output nfps_pkg::dp_status_t      status,
  input  logic signed [31:0]        point_re,
  input  logic signed [31:0]        point_im,
  input  logic [1:0]                zero_index,
  input  logic signed [31:0]        zero_re,
  input  logic signed [31:0]        zero_im,
  input  logic signed [15:0]        zero_weight,
  input  logic [31:0]               tolerance_sq,
  output logic                      done,
  output logic signed [31:0]        final_re,
  output logic signed [31:0]        final_im,
  output logic [7:0]                iterations,
  output logic [1:0]                nearest_zero
);
  import nfps_pkg::*;

  localparam int SW  = 59 + $clog2(MAX_ZEROS);
  localparam int DW  = 2 * FRAC_BITS + 35;
  localparam int SHW = $clog2(DW);
  localparam int S2W = $clog2(SW);

  function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
    logic signed [31:0] r;
    if (v > 43'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -43'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [31:0] mag33(input logic signed [32:0] v);
    logic signed [32:0] n;
    n = -v;
    return v[32] ? n[31:0] : v[31:0];
  endfunction

  // Zero table, undefined until loaded.
  logic signed [31:0] tbl_re [MAX_ZEROS];
  logic signed [31:0] tbl_im [MAX_ZEROS];
  logic signed [15:0] tbl_w  [MAX_ZEROS];

  logic signed [31:0] z_re, z_im;
  logic signed [32:0] t_re, t_im;
  logic [15:0]        w_mag;
  logic               w_neg;
  logic               s_bit;
  logic [SW-1:0]      a_re, a_im;
  logic [SQ_W-1:0]    acc;
  logic [NUM_W-1:0]   num_re, num_im;
  logic signed [SW-1:0] sum_re, sum_im;
  logic [S2W-1:0]     s2;
  logic [IW-1:0]      best_idx;
  logic [SQ_W-1:0]    best_d;

  // Combinational values.
  logic signed [31:0] sel_re, sel_im;
  logic signed [15:0] sel_w;
  logic signed [32:0] diff_re, diff_im;
  logic [31:0]        mag_re, mag_im;
  logic               norm_s;
  logic [15:0]        w_abs;
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [63:0]        prod;
  logic [SHW-1:0]     sh_term, sh_step;
  logic [DW-1:0]      dvd_re, dvd_im;
  logic               div_start, div_step, div_done;
  logic [CAP_W-1:0]   quo_re, quo_im;
  logic signed [SW-1:0] q_sre, q_sim, term_re, term_im;
  logic [SW-1:0]      abs_sre, abs_sim;
  logic signed [42:0] q_pre, q_pim, stp_re, stp_im, new_re, new_im;
  logic signed [31:0] sat_re, sat_im;
  logic [31:0]        dz_re, dz_im;
  logic               slot_ok;

  // Differences, magnitudes and the multiplier operand selection.
  always_comb begin
    sel_re  = tbl_re[idx];
    sel_im  = tbl_im[idx];
    sel_w   = tbl_w[idx];
    diff_re = {z_re[31], z_re} - {sel_re[31], sel_re};
    diff_im = {z_im[31], z_im} - {sel_im[31], sel_im};
    mag_re  = mag33(t_re);
    mag_im  = mag33(t_im);
    norm_s  = mag_re[31] | mag_im[31];
    w_abs   = sel_w[15] ? 16'(-sel_w) : sel_w;
    slot_ok = 32'(zero_index) < MAX_ZEROS;
    unique case (cmd.op)
      DP_SQ_IM:  begin mul_a = a_im[MUL_W-1:0];   mul_b = a_im[MUL_W-1:0]; end
      DP_NUM_RE: begin mul_a = MUL_W'(w_mag);     mul_b = a_re[MUL_W-1:0]; end
      DP_NUM_IM: begin mul_a = MUL_W'(w_mag);     mul_b = a_im[MUL_W-1:0]; end
      default:   begin mul_a = a_re[MUL_W-1:0];   mul_b = a_re[MUL_W-1:0]; end
    endcase
    prod = {32'b0, mul_a} * {32'b0, mul_b};
  end

  // Dividend alignment for the term and step divisions.
  always_comb begin
    sh_term = SHW'(2 * FRAC_BITS - 12) - SHW'(s_bit);
    if (int'(s2) < 2 * FRAC_BITS) sh_step = SHW'(2 * FRAC_BITS) - SHW'(s2);
    else sh_step = '0;
    div_start = (cmd.op == DP_TDIV) || (cmd.op == DP_PDIV);
    div_step  = cmd.op == DP_PDIV;
    if (div_step) begin
      dvd_re = DW'(a_re[NORM_W-1:0]) << sh_step;
      dvd_im = DW'(a_im[NORM_W-1:0]) << sh_step;
    end else begin
      dvd_re = DW'(num_re) << sh_term;
      dvd_im = DW'(num_im) << sh_term;
    end
  end

  nfps_divider #(.DW(DW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .step_mode (div_step),
    .num_re    (dvd_re),
    .num_im    (dvd_im),
    .den       (acc[DEN_W-1:0]),
    .done      (div_done),
    .quo_re    (quo_re),
    .quo_im    (quo_im)
  );

  // Signed terms, sum magnitudes and the Newton update.
  always_comb begin
    q_sre   = SW'(quo_re);
    q_sim   = SW'(quo_im);
    term_re = (w_neg != t_re[32]) ? -q_sre : q_sre;
    term_im = (w_neg == t_im[32]) ? -q_sim : q_sim;
    abs_sre = sum_re[SW-1] ? SW'(-sum_re) : SW'(sum_re);
    abs_sim = sum_im[SW-1] ? SW'(-sum_im) : SW'(sum_im);
    q_pre   = 43'(quo_re);
    q_pim   = 43'(quo_im);
    stp_re  = sum_re[SW-1] ? -q_pre : q_pre;
    stp_im  = sum_im[SW-1] ? q_pim : -q_pim;
    new_re  = 43'(z_re) - stp_re;
    new_im  = 43'(z_im) - stp_im;
    sat_re  = sat32(new_re);
    sat_im  = sat32(new_im);
    dz_re   = mag33({z_re[31], z_re} - {sat_re[31], sat_re});
    dz_im   = mag33({z_im[31], z_im} - {sat_im[31], sat_im});
  end

  // Zero table writes.
  always_ff @(posedge clk) begin
    if (cmd.op == DP_LOAD && slot_ok) begin
      tbl_re[IW'(zero_index)] <= zero_re;
      tbl_im[IW'(zero_index)] <= zero_im;
      tbl_w[IW'(zero_index)]  <= zero_weight;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_INIT: begin
        z_re <= point_re;
        z_im <= point_im;
      end
      DP_ITER: begin
        sum_re <= '0;
        sum_im <= '0;
      end
      DP_DIFF: begin
        t_re  <= diff_re;
        t_im  <= diff_im;
        w_mag <= w_abs;
        w_neg <= sel_w[15];
      end
      DP_TNORM: begin
        s_bit <= norm_s;
        a_re  <= SW'(norm_s ? mag_re >> 1 : mag_re);
        a_im  <= SW'(norm_s ? mag_im >> 1 : mag_im);
      end
      DP_NMAG: begin
        a_re <= SW'(mag_re);
        a_im <= SW'(mag_im);
      end
      DP_SQ_RE:  acc <= SQ_W'(prod);
      DP_SQ_IM:  acc <= acc + SQ_W'(prod);
      DP_NUM_RE: num_re <= prod[NUM_W-1:0];
      DP_NUM_IM: num_im <= prod[NUM_W-1:0];
      DP_TACC: begin
        sum_re <= sum_re + term_re;
        sum_im <= sum_im + term_im;
      end
      DP_SNORM_INIT: begin
        a_re <= abs_sre;
        a_im <= abs_sim;
        s2   <= '0;
      end
      DP_SNORM_STEP: begin
        a_re <= a_re >> 1;
        a_im <= a_im >> 1;
        s2   <= s2 + S2W'(1);
      end
      DP_UPDATE: begin
        z_re <= sat_re;
        z_im <= sat_im;
        a_re <= SW'(dz_re);
        a_im <= SW'(dz_im);
      end
      DP_NCMP: begin
        if (idx == '0 || acc < best_d) begin
          best_idx <= idx;
          best_d   <= acc;
        end
      end
      DP_OUT: begin
        final_re     <= z_re;
        final_im     <= z_im;
        iterations   <= cmd.iterations;
        nearest_zero <= 2'(best_idx);
      end
      default: ;
    endcase
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.op == DP_OUT;
    end
  end

  // Status toward the controller.
  always_comb begin
    status.diff_zero  = (t_re == '0) && (t_im == '0);
    status.sum_zero   = (sum_re == '0) && (sum_im == '0);
    status.norm_ok    = (a_re[SW-1:NORM_W] == '0) && (a_im[SW-1:NORM_W] == '0);
    status.div_done   = div_done;
    status.small_step = (a_re[SW-1:SMALL_W] == '0) && (a_im[SW-1:SMALL_W] == '0);
    status.below_tol  = acc < SQ_W'(tolerance_sq);
  end

endmodule

>>> sv/nfps_control.sv
// ---------------------------------------------------------------------------
// Newton fractal solver controller
// Sequences loads, the per zero term loop, the step division, the stop
// tests and the nearest zero search.
// ---------------------------------------------------------------------------
module nfps_control #(
  parameter int MAX_ZEROS = 4,
  localparam int IW = (MAX_ZEROS > 1) ? $clog2(MAX_ZEROS) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 operation,
  output logic                 busy,
  input  logic [7:0]           iteration_limit,
  input  logic [2:0]           zero_count,
  output nfps_pkg::dp_cmd_t    cmd,
  output logic [IW-1:0]        idx,
  input  nfps_pkg::dp_status_t status
);
  import nfps_pkg::*;

  localparam int KW = $clog2(MAX_ZEROS + 1);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_ITER  = 5'd1;
  localparam logic [4:0] S_TDIFF = 5'd2;
  localparam logic [4:0] S_TNORM = 5'd3;
  localparam logic [4:0] S_TSQR  = 5'd4;
  localparam logic [4:0] S_TSQI  = 5'd5;
  localparam logic [4:0] S_TNUMR = 5'd6;
  localparam logic [4:0] S_TNUMI = 5'd7;
  localparam logic [4:0] S_TDIV  = 5'd8;
  localparam logic [4:0] S_TWAIT = 5'd9;
  localparam logic [4:0] S_TACC  = 5'd10;
  localparam logic [4:0] S_SCHK  = 5'd11;
  localparam logic [4:0] S_SNORM = 5'd12;
  localparam logic [4:0] S_PSQR  = 5'd13;
  localparam logic [4:0] S_PSQI  = 5'd14;
  localparam logic [4:0] S_PDIV  = 5'd15;
  localparam logic [4:0] S_PWAIT = 5'd16;
  localparam logic [4:0] S_UPD   = 5'd17;
  localparam logic [4:0] S_UCHK  = 5'd18;
  localparam logic [4:0] S_ESQR  = 5'd19;
  localparam logic [4:0] S_ESQI  = 5'd20;
  localparam logic [4:0] S_ECHK  = 5'd21;
  localparam logic [4:0] S_NDIFF = 5'd22;
  localparam logic [4:0] S_NMAG  = 5'd23;
  localparam logic [4:0] S_NSQR  = 5'd24;
  localparam logic [4:0] S_NSQI  = 5'd25;
  localparam logic [4:0] S_NCMP  = 5'd26;
  localparam logic [4:0] S_OUT   = 5'd27;

  logic [4:0]    state, state_next;
  logic [KW-1:0] k, k_next;
  logic [7:0]    iter, iter_next;
  logic [7:0]    limit_eff;
  logic [KW-1:0] count_eff;
  logic [KW-1:0] k_inc;

  // Limits with the out of range values folded in.
  always_comb begin
    limit_eff = (iteration_limit == 8'd0) ? 8'd1 : iteration_limit;
    if (zero_count == 3'd0) count_eff = KW'(1);
    else if (int'(zero_count) > MAX_ZEROS) count_eff = KW'(MAX_ZEROS);
    else count_eff = KW'(zero_count);
    k_inc = k + KW'(1);
  end

  // Next state and datapath command.
  always_comb begin
    state_next = state;
    k_next     = k;
    iter_next  = iter;
    cmd.op     = DP_NOP;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (operation) begin
            cmd.op = DP_LOAD;
          end else begin
            cmd.op     = DP_INIT;
            iter_next  = 8'd0;
            state_next = S_ITER;
          end
        end
      end
      S_ITER: begin
        cmd.op     = DP_ITER;
        iter_next  = iter + 8'd1;
        k_next     = '0;
        state_next = S_TDIFF;
      end
      S_TDIFF: begin
        cmd.op     = DP_DIFF;
        state_next = S_TNORM;
      end
      S_TNORM: begin
        // An exact hit ends the iteration with z unchanged.
        cmd.op = DP_TNORM;
        if (status.diff_zero) begin
          k_next     = '0;
          state_next = S_NDIFF;
        end else begin
          state_next = S_TSQR;
        end
      end
      S_TSQR: begin
        cmd.op     = DP_SQ_RE;
        state_next = S_TSQI;
      end
      S_TSQI: begin
        cmd.op     = DP_SQ_IM;
        state_next = S_TNUMR;
      end
      S_TNUMR: begin
        cmd.op     = DP_NUM_RE;
        state_next = S_TNUMI;
      end
      S_TNUMI: begin
        cmd.op     = DP_NUM_IM;
        state_next = S_TDIV;
      end
      S_TDIV: begin
        cmd.op     = DP_TDIV;
        state_next = S_TWAIT;
      end
      S_TWAIT: begin
        if (status.div_done) state_next = S_TACC;
      end
      S_TACC: begin
        cmd.op = DP_TACC;
        k_next = k_inc;
        state_next = (k_inc == count_eff) ? S_SCHK : S_TDIFF;
      end
      S_SCHK: begin
        if (status.sum_zero) begin
          k_next     = '0;
          state_next = S_NDIFF;
        end else begin
          cmd.op     = DP_SNORM_INIT;
          state_next = S_SNORM;
        end
      end
      S_SNORM: begin
        if (status.norm_ok) state_next = S_PSQR;
        else cmd.op = DP_SNORM_STEP;
      end
      S_PSQR: begin
        cmd.op     = DP_SQ_RE;
        state_next = S_PSQI;
      end
      S_PSQI: begin
        cmd.op     = DP_SQ_IM;
        state_next = S_PDIV;
      end
      S_PDIV: begin
        cmd.op     = DP_PDIV;
        state_next = S_PWAIT;
      end
      S_PWAIT: begin
        if (status.div_done) state_next = S_UPD;
      end
      S_UPD: begin
        cmd.op     = DP_UPDATE;
        state_next = S_UCHK;
      end
      S_UCHK: begin
        if (iter >= limit_eff) begin
          k_next     = '0;
          state_next = S_NDIFF;
        end else if (status.small_step) begin
          state_next = S_ESQR;
        end else begin
          state_next = S_ITER;
        end
      end
      S_ESQR: begin
        cmd.op     = DP_SQ_RE;
        state_next = S_ESQI;
      end
      S_ESQI: begin
        cmd.op     = DP_SQ_IM;
        state_next = S_ECHK;
      end
      S_ECHK: begin
        if (status.below_tol) begin
          k_next     = '0;
          state_next = S_NDIFF;
        end else begin
          state_next = S_ITER;
        end
      end
      S_NDIFF: begin
        cmd.op     = DP_DIFF;
        state_next = S_NMAG;
      end
      S_NMAG: begin
        cmd.op     = DP_NMAG;
        state_next = S_NSQR;
      end
      S_NSQR: begin
        cmd.op     = DP_SQ_RE;
        state_next = S_NSQI;
      end
      S_NSQI: begin
        cmd.op     = DP_SQ_IM;
        state_next = S_NCMP;
      end
      S_NCMP: begin
        cmd.op = DP_NCMP;
        k_next = k_inc;
        state_next = (k_inc == count_eff) ? S_OUT : S_NDIFF;
      end
      S_OUT: begin
        cmd.op     = DP_OUT;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    cmd.iterations = iter;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= '0;
      iter  <= 8'd0;
    end else begin
      state <= state_next;
      k     <= k_next;
      iter  <= iter_next;
    end
  end

  assign busy = state != S_IDLE;
  assign idx  = k[IW-1:0];

endmodule

>>> sv/newton_fractal_pixel_solver_unit.sv
// A load is taken while the unit stays idle. Pixel work uses one shared bit-serial divider
// with DW = 2*FRAC_BITS+35 dividend bits for each division pair.
// One item is in work at a time; the result strobe follows the last search step.
// Reset is synchronous; it clears control and loads the register defaults.
// The zero table has no reset and holds garbage until loaded.
// ---------------------------------------------------------------------------
// Newton fractal pixel solver unit
// Top level: configuration registers, controller and datapath.
// ---------------------------------------------------------------------------
module newton_fractal_pixel_solver_unit #(
  parameter int MAX_ZEROS = 4,
  parameter int FRAC_BITS = 28
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               operation,
  input  logic signed [31:0] point_re,
  input  logic signed [31:0] point_im,
  input  logic [1:0]         zero_index,
  input  logic signed [31:0] zero_re,
  input  logic signed [31:0] zero_im,
  input  logic signed [15:0] zero_weight,
  input  logic               config_write,
  input  logic [1:0]         config_index,
  input  logic [31:0]        config_data,
  output logic               done,
  output logic signed [31:0] final_re,
  output logic signed [31:0] final_im,
  output logic [7:0]         iterations,
  output logic [1:0]         nearest_zero
);
  import nfps_pkg::*;

  localparam int IW = (MAX_ZEROS > 1) ? $clog2(MAX_ZEROS) : 1;

  logic [7:0]  iteration_limit;
  logic [2:0]  zero_count;
  logic [31:0] tolerance_sq;
  dp_cmd_t     cmd;
  dp_status_t  status;
  logic [IW-1:0] idx;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      iteration_limit <= RESET_ITERATION_LIMIT;
      zero_count      <= RESET_ZERO_COUNT;
      tolerance_sq    <= RESET_TOLERANCE_SQ;
    end else if (config_write) begin
      unique case (config_index)
        CFG_ITERATION_LIMIT: iteration_limit <= config_data[7:0];
        CFG_ZERO_COUNT:      zero_count      <= config_data[2:0];
        CFG_TOLERANCE_SQ:    tolerance_sq    <= config_data;
        default: ;
      endcase
    end
  end

  nfps_control #(.MAX_ZEROS(MAX_ZEROS)) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .operation       (operation),
    .busy            (busy),
    .iteration_limit (iteration_limit),
    .zero_count      (zero_count),
    .cmd             (cmd),
    .idx             (idx),
    .status          (status)
  );

  nfps_datapath #(.MAX_ZEROS(MAX_ZEROS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .idx          (idx),
    .status       (status),
    .point_re     (point_re),
    .point_im     (point_im),
    .zero_index   (zero_index),
    .zero_re      (zero_re),
    .zero_im      (zero_im),
    .zero_weight  (zero_weight),
    .tolerance_sq (tolerance_sq),
    .done         (done),
    .final_re     (final_re),
    .final_im     (final_im),
    .iterations   (iterations),
    .nearest_zero (nearest_zero)
  );

`ifndef NO_ASSERTIONS
  // A result only follows a pixel request that was in work.
  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result without a pixel request in work");

  // A load request finishes in its own cycle.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && operation) |=> !busy)
    else $error("load request left the unit busy");

  // A pixel request never produces a result in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !operation) |=> (busy && !done))
    else $error("pixel request did not start work");

  // At least one Newton step is always counted.
  assert property (@(posedge clk) disable iff (rst) done |-> (iterations != 8'd0))
    else $error("result with zero iterations");
`endif

endmodule

>>> tb/sv/newton_fractal_pixel_solver_unit_checker.sv
// ---------------------------------------------------------------------------
// Newton fractal pixel solver result checker
// Watches the request, configuration and result ports of the solver, keeps
// its own copy of the zero table and the registers, predicts each pixel
// result when its request is accepted and compares every strobed result
// with the oldest prediction.
// ---------------------------------------------------------------------------
module newton_fractal_pixel_solver_unit_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic               operation,
  input  logic signed [31:0] point_re,
  input  logic signed [31:0] point_im,
  input  logic [1:0]         zero_index,
  input  logic signed [31:0] zero_re,
  input  logic signed [31:0] zero_im,
  input  logic signed [15:0] zero_weight,
  input  logic               config_write,
  input  logic [1:0]         config_index,
  input  logic [31:0]        config_data,
  input  logic               done,
  input  logic signed [31:0] final_re,
  input  logic signed [31:0] final_im,
  input  logic [7:0]         iterations,
  input  logic [1:0]         nearest_zero,
  output int                 pending,
  output int                 errors
);
  import nfps_pkg::*;

  localparam int ZEROS = 4;
  localparam int FRAC  = 28;
  localparam logic [63:0] TERM_LIMIT = (64'd1 << 58) - 64'd1;
  localparam logic [63:0] STEP_LIMIT = 64'd1 << 40;
  localparam logic [63:0] PART_LIMIT = 64'd1 << 31;

  typedef struct {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic [7:0]         steps;
    logic [1:0]         nearest;
  } pixel_result_t;

  pixel_result_t expected_pixels[$];

  // Shadow zero table and registers.
  longint      root_re_tab[ZEROS];
  longint      root_im_tab[ZEROS];
  longint      root_w_tab[ZEROS];
  logic [7:0]  limit_reg;
  logic [2:0]  count_reg;
  logic [31:0] tol_reg;

  function automatic logic [63:0] mag(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint apply_sign(logic [63:0] q, bit neg);
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Shift that brings both magnitudes below 2^31.
  function automatic int norm_shift(logic [63:0] a, logic [63:0] b);
    int s;
    s = 0;
    while ((a >> s) >= PART_LIMIT || (b >> s) >= PART_LIMIT) s++;
    return s;
  endfunction

  // floor(num * 2^sh / den), saturated to cap.
  function automatic logic [63:0] scaled_quotient(logic [63:0] num, logic [63:0] den,
                                                  int sh, logic [63:0] cap);
    logic [63:0] q;
    logic [63:0] r;
    q = num / den;
    r = num % den;
    if (q > cap) return cap;
    for (int i = 0; i < sh; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q + 64'd1;
      end
      if (q > cap) return cap;
    end
    return q;
  endfunction

  // Newton iteration of one pixel followed by the nearest zero search.
  function automatic pixel_result_t newton_solve(longint zr0, longint zi0);
    pixel_result_t res;
    longint zr, zi, sr, si, dr, di, w, stre, stim, nr, ni;
    logic [63:0] ar, ai, m, qr, qi, e, xr, xi;
    logic [64:0] sq_dist, best_dist;
    int limit, count, iter, s, sh, best;
    bit stop, hit;
    zr = zr0;
    zi = zi0;
    limit = (limit_reg == 8'd0) ? 1 : int'(limit_reg);
    count = (count_reg == 3'd0) ? 1 : (count_reg > ZEROS) ? ZEROS : int'(count_reg);
    iter = 0;
    stop = 0;
    while (!stop) begin
      sr = 0;
      si = 0;
      hit = 0;
      iter++;
      for (int k = 0; k < count; k++) begin
        dr = zr - root_re_tab[k];
        di = zi - root_im_tab[k];
        w = root_w_tab[k];
        if (dr == 0 && di == 0) begin
          hit = 1;
        end else begin
          s = norm_shift(mag(dr), mag(di));
          ar = mag(dr) >> s;
          ai = mag(di) >> s;
          m = ar * ar + ai * ai;
          sh = 2 * FRAC - 12 - s;
          if (sh < 0) sh = 0;
          qr = scaled_quotient(mag(w) * ar, m, sh, TERM_LIMIT);
          qi = scaled_quotient(mag(w) * ai, m, sh, TERM_LIMIT);
          sr += apply_sign(qr, (w < 0) != (dr < 0));
          si += apply_sign(qi, (w < 0) == (di < 0));
        end
      end
      if (hit || (sr == 0 && si == 0)) begin
        stop = 1;
      end else begin
        ar = mag(sr);
        ai = mag(si);
        s = norm_shift(ar, ai);
        ar = ar >> s;
        ai = ai >> s;
        m = ar * ar + ai * ai;
        sh = 2 * FRAC - s;
        if (sh < 0) sh = 0;
        qr = scaled_quotient(ar, m, sh, STEP_LIMIT);
        qi = scaled_quotient(ai, m, sh, STEP_LIMIT);
        stre = apply_sign(qr, sr < 0);
        stim = apply_sign(qi, si >= 0);
        nr = clip32(zr - stre);
        ni = clip32(zi - stim);
        dr = zr - nr;
        di = zi - ni;
        zr = nr;
        zi = ni;
        if (iter >= limit) begin
          stop = 1;
        end else if (mag(dr) < 64'd65536 && mag(di) < 64'd65536) begin
          e = mag(dr) * mag(dr) + mag(di) * mag(di);
          if (e < {32'd0, tol_reg}) stop = 1;
        end
      end
    end
    // Closest active zero by exact squared distance; ties keep the lower index.
    best = 0;
    best_dist = '0;
    for (int k = 0; k < count; k++) begin
      xr = mag(zr - root_re_tab[k]);
      xi = mag(zi - root_im_tab[k]);
      sq_dist = {1'b0, xr * xr} + {1'b0, xi * xi};
      if (k == 0 || sq_dist < best_dist) begin
        best = k;
        best_dist = sq_dist;
      end
    end
    res.re = zr[31:0];
    res.im = zi[31:0];
    res.steps = iter[7:0];
    res.nearest = best[1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  assign pending = expected_pixels.size();

  // Track requests, register writes and results.
  always @(posedge clk) begin
    pixel_result_t exp_r;
    if (rst) begin
      limit_reg <= RESET_ITERATION_LIMIT;
      count_reg <= RESET_ZERO_COUNT;
      tol_reg   <= RESET_TOLERANCE_SQ;
    end else begin
      if (config_write) begin
        case (config_index)
          CFG_ITERATION_LIMIT: limit_reg <= config_data[7:0];
          CFG_ZERO_COUNT:      count_reg <= config_data[2:0];
          CFG_TOLERANCE_SQ:    tol_reg   <= config_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (operation) begin
          if (zero_index < ZEROS) begin
            root_re_tab[zero_index] = longint'(zero_re);
            root_im_tab[zero_index] = longint'(zero_im);
            root_w_tab[zero_index]  = longint'(zero_weight);
          end
        end else begin
          expected_pixels.push_back(newton_solve(longint'(point_re), longint'(point_im)));
        end
      end
      if (done) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("results waiting", 1, 0);
        end else begin
          exp_r = expected_pixels.pop_front();
          if (final_re !== exp_r.re) report_mismatch("final_re", final_re, exp_r.re);
          if (final_im !== exp_r.im) report_mismatch("final_im", final_im, exp_r.im);
          if (iterations !== exp_r.steps)
            report_mismatch("iterations", iterations, exp_r.steps);
          if (nearest_zero !== exp_r.nearest)
            report_mismatch("nearest_zero", nearest_zero, exp_r.nearest);
        end
      end
    end
  end

  initial errors = 0;

endmodule

>>> tb/sv/newton_fractal_pixel_solver_unit_tb.sv
// ---------------------------------------------------------------------------
// Newton fractal pixel solver testbench
// Loads zero tables and sends pixel requests, first a directed set and then
// random phases under varied register settings; a checker beside the solver
// predicts and compares every result.
// ---------------------------------------------------------------------------
module newton_fractal_pixel_solver_unit_tb;
  import nfps_pkg::*;

  localparam int STALL_LIMIT = 600000;
  localparam int PHASES      = 13;
  localparam logic OP_SOLVE  = 1'b0;
  localparam logic OP_LOAD   = 1'b1;
  localparam logic signed [31:0] ONE  = 32'sh1000_0000;
  localparam logic signed [15:0] W_ONE = 16'sd4096;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic               operation;
  logic signed [31:0] point_re;
  logic signed [31:0] point_im;
  logic [1:0]         zero_index;
  logic signed [31:0] zero_re;
  logic signed [31:0] zero_im;
  logic signed [15:0] zero_weight;
  logic               config_write;
  logic [1:0]         config_index;
  logic [31:0]        config_data;
  logic               done;
  logic signed [31:0] final_re;
  logic signed [31:0] final_im;
  logic [7:0]         iterations;
  logic [1:0]         nearest_zero;
  int                 pending;
  int                 errors;

  // Table contents as loaded, used to aim pixels near zeros.
  logic signed [31:0] table_re[4];
  logic signed [31:0] table_im[4];
  int                 sent_count;
  bit                 gaps_on;
  int                 quiet_cycles;

  newton_fractal_pixel_solver_unit dut (.*);

  newton_fractal_pixel_solver_unit_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("newton_fractal_pixel_solver_unit test failed");
        $finish;
      end
    end
  end

  // Present one request and hold it until the solver accepts it.
  task automatic send_request(logic op, logic signed [31:0] pr, logic signed [31:0] pi,
                              logic [1:0] idx, logic signed [31:0] zr,
                              logic signed [31:0] zi, logic signed [15:0] zw);
    bit ok;
    if (gaps_on && $urandom_range(0, 99) < 35) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start       <= 1'b1;
    operation   <= op;
    point_re    <= pr;
    point_im    <= pi;
    zero_index  <= idx;
    zero_re     <= zr;
    zero_im     <= zi;
    zero_weight <= zw;
    do begin
      @(negedge clk);
      ok = !busy;
      @(posedge clk);
    end while (!ok);
    if (op == OP_LOAD) begin
      table_re[idx] = zr;
      table_im[idx] = zi;
    end
    sent_count++;
  endtask

  task automatic load_zero(logic [1:0] idx, logic signed [31:0] zr, logic signed [31:0] zi,
                           logic signed [15:0] zw);
    send_request(OP_LOAD, $urandom, $urandom, idx, zr, zi, zw);
  endtask

  task automatic solve_pixel(logic signed [31:0] pr, logic signed [31:0] pi);
    send_request(OP_SOLVE, pr, pi, 2'($urandom), $urandom, $urandom, 16'($urandom));
  endtask

  // Drop the request line and wait until every result is in and the solver is idle.
  task automatic drain;
    start <= 1'b0;
    do @(negedge clk); while (pending != 0 || busy);
    repeat (8) @(posedge clk);
  endtask

  // One register write, then the write strobe is dropped again.
  task automatic write_register(logic [1:0] idx, logic [31:0] value);
    config_write <= 1'b1;
    config_index <= idx;
    config_data  <= value;
    @(posedge clk);
    config_write <= 1'b0;
    @(posedge clk);
  endtask

  // One random request: mostly pixels near table zeros, some loads and noise.
  task automatic random_request;
    int sel;
    int k;
    logic signed [31:0] wiggle_re;
    logic signed [31:0] wiggle_im;
    logic signed [15:0] w;
    sel = $urandom_range(0, 99);
    k = $urandom_range(0, 3);
    wiggle_re = $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
    wiggle_im = $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
    if (sel < 14) begin
      case ($urandom_range(0, 4))
        0:       w = 16'($urandom);
        1:       w = -$signed(16'($urandom_range(1024, 12288)));
        default: w = 16'($urandom_range(1, 3) * 4096);
      endcase
      if ($urandom_range(0, 4) == 0)
        load_zero(2'(k), $urandom, $urandom, w);
      else
        load_zero(2'(k), $signed($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000,
                  $signed($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000, w);
    end else if (sel < 60) begin
      solve_pixel(table_re[k] + wiggle_re, table_im[k] + wiggle_im);
    end else if (sel < 68) begin
      solve_pixel(table_re[k], table_im[k]);
    end else if (sel < 85) begin
      solve_pixel($signed($urandom_range(0, 32'h6000_0000)) - 32'sh3000_0000,
                  $signed($urandom_range(0, 32'h6000_0000)) - 32'sh3000_0000);
    end else begin
      solve_pixel($urandom, $urandom);
    end
  endtask

  // Stimulus and verdict.
  initial begin
    int items;
    logic [31:0] tol;
    rst          <= 1'b1;
    start        <= 1'b0;
    operation    <= OP_SOLVE;
    point_re     <= '0;
    point_im     <= '0;
    zero_index   <= '0;
    zero_re      <= '0;
    zero_im      <= '0;
    zero_weight  <= '0;
    config_write <= 1'b0;
    config_index <= CFG_ITERATION_LIMIT;
    config_data  <= '0;
    sent_count = 0;
    gaps_on = 1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the reset settings: cube roots of unity plus an extreme slot.
    load_zero(2'd0, ONE, 32'sd0, W_ONE);
    load_zero(2'd1, -32'sh0800_0000, 32'sh0DDB_3D74, W_ONE);
    load_zero(2'd2, -32'sh0800_0000, -32'sh0DDB_3D74, W_ONE);
    load_zero(2'd3, 32'sh7FFF_FFFF, -32'sh8000_0000, -16'sh8000);
    solve_pixel(ONE, 32'sd0);
    solve_pixel(32'sh0E00_0000, 32'sh0100_0000);
    solve_pixel(32'sd0, 32'sd0);
    solve_pixel(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    solve_pixel(-32'sh8000_0000, -32'sh8000_0000);
    solve_pixel(-32'sh0800_0000, 32'sh0DDB_3D74);
    solve_pixel(-32'sh0700_0000, -32'sh0D00_0000);
    drain;
    // Weights that cancel at the midpoint give a zero sum; all weights zero as well.
    write_register(CFG_ZERO_COUNT, 32'd2);
    load_zero(2'd0, ONE, 32'sd0, W_ONE);
    load_zero(2'd1, -ONE, 32'sd0, W_ONE);
    solve_pixel(32'sd0, 32'sd0);
    solve_pixel(32'sd0, 32'sh0400_0000);
    load_zero(2'd0, ONE, 32'sd0, 16'sd0);
    load_zero(2'd1, -ONE, 32'sd0, 16'sd0);
    solve_pixel(32'sh0100_0000, 32'sh0100_0000);
    load_zero(2'd0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'sh7FFF);
    load_zero(2'd1, -32'sh8000_0000, -32'sh8000_0000, W_ONE);
    solve_pixel(-32'sh8000_0000, 32'sh7FFF_FFFF);
    drain;

    // Random phases, each under its own register settings.
    for (int p = 1; p <= PHASES; p++) begin
      case (p)
        1:       tol = 32'd0;
        2:       tol = 32'hFFFF_FFFF;
        3:       tol = RESET_TOLERANCE_SQ;
        default: tol = ($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(0, 32'h0010_0000);
      endcase
      if (p == 1)
        write_register(CFG_ITERATION_LIMIT, 32'd255);
      else if (p == 2)
        write_register(CFG_ITERATION_LIMIT, 32'd0);
      else
        write_register(CFG_ITERATION_LIMIT, $urandom_range(1, 4));
      write_register(CFG_ZERO_COUNT, (p == 1) ? 32'd4 : (p == 2) ? 32'd7 : $urandom_range(0, 7));
      write_register(CFG_TOLERANCE_SQ, tol);
      items = (p == 1) ? 2 : 23;
      for (int i = 0; i < items; i++) begin
        gaps_on = !(sent_count >= 120 && sent_count < 175);
        if (p == 1)
          solve_pixel($urandom, $urandom);
        else
          random_request();
      end
      drain;
    end

    repeat (50) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("newton_fractal_pixel_solver_unit test passed");
    end else begin
      $display("newton_fractal_pixel_solver_unit test failed");
    end
    $finish;
  end

endmodule

>>> newton_fractal_pixel_solver_unit.f
sv/nfps_pkg.sv
sv/nfps_divider.sv
sv/nfps_datapath.sv
sv/nfps_control.sv
sv/newton_fractal_pixel_solver_unit.sv
tb/sv/newton_fractal_pixel_solver_unit_checker.sv
tb/sv/newton_fractal_pixel_solver_unit_tb.sv
